// File: design/glqr_pkg.sv
package glqr_pkg;

  // number formats
  localparam int FRAC_BITS   = 16;
  localparam int POLY_DEGREE = 3;
  localparam int NUM_COEFS   = POLY_DEGREE + 1;
  localparam int NUM_STATES  = 6;
  localparam int NUM_ROWS    = 2;
  localparam int NUM_GAINS   = NUM_ROWS * NUM_STATES;
  localparam int TABLE_DEPTH = NUM_GAINS * NUM_COEFS;
  localparam int TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int PTR_W       = TAB_AW + 1;

  // state column that carries velocity
  localparam int VEL_COL = 3;

  localparam int DATA_W  = 32;
  localparam int LEN_W   = 18;
  localparam int IDX_W   = 6;
  localparam int ERR_W   = DATA_W + 1;
  localparam int PROD_W  = 2 * ERR_W;
  localparam int SHIFT_W = PROD_W - FRAC_BITS;
  localparam int SUM_W   = SHIFT_W + 3;

  localparam int IN_TDATA_W  = 280;
  localparam int OUT_TDATA_W = 2 * DATA_W;

  // loop counters
  localparam int PW_W  = (POLY_DEGREE > 1) ? $clog2(POLY_DEGREE) : 1;
  localparam int COL_W = $clog2(NUM_STATES);

  // operation codes carried in tuser
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // microprogram addresses
  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] U_RD0    = 3'd0;
  localparam logic [UPC_W-1:0] U_LDA    = 3'd1;
  localparam logic [UPC_W-1:0] U_MLEN   = 3'd2;
  localparam logic [UPC_W-1:0] U_HORN   = 3'd3;
  localparam logic [UPC_W-1:0] U_MERR   = 3'd4;
  localparam logic [UPC_W-1:0] U_ACCUM  = 3'd5;
  localparam logic [UPC_W-1:0] U_ROWEND = 3'd6;
  localparam logic [UPC_W-1:0] U_EMIT   = 3'd7;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_PW_MORE,
    JMP_COL_MORE,
    JMP_ROW_MORE,
    JMP_DONE
  } jmp_t;

  typedef struct packed {
    logic             rd;
    logic             ld_acc;
    logic             mul_len;
    logic             horner;
    logic             mul_err;
    logic             add_sum;
    logic             row_end;
    logic             emit;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // datapath controls from the sequencer
  typedef struct packed {
    logic start;
    logic ld_acc;
    logic mul_len;
    logic horner;
    logic mul_err;
    logic add_sum;
    logic row_end;
    logic row;
  } dp_ctl_t;

  // microprogram rom
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    w = '0;
    w.jmp = JMP_NEXT;
    case (addr)
      U_RD0: begin
        w.rd = 1'b1;
      end
      U_LDA: begin
        w.ld_acc = 1'b1;
      end
      U_MLEN: begin
        w.mul_len = 1'b1;
        w.rd      = 1'b1;
      end
      U_HORN: begin
        w.horner = 1'b1;
        w.jmp    = JMP_PW_MORE;
        w.target = U_MLEN;
      end
      U_MERR: begin
        w.mul_err = 1'b1;
      end
      U_ACCUM: begin
        w.add_sum = 1'b1;
        w.jmp     = JMP_COL_MORE;
        w.target  = U_RD0;
      end
      U_ROWEND: begin
        w.row_end = 1'b1;
        w.jmp     = JMP_ROW_MORE;
        w.target  = U_RD0;
      end
      U_EMIT: begin
        w.emit = 1'b1;
        w.jmp  = JMP_DONE;
      end
      default: begin
        w.jmp = JMP_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/glqr_datapath.sv
module glqr_datapath
  import glqr_pkg::*;
(
  input  logic              clk,
  input  dp_ctl_t           ctl,
  input  logic [DATA_W-1:0] rdata,
  input  logic [LEN_W-1:0]  len,
  input  logic [ERR_W-1:0]  err,
  output logic [DATA_W-1:0] wheel,
  output logic [DATA_W-1:0] joint,
  output logic              sat
);

  typedef struct packed {
    logic              clip;
    logic [DATA_W-1:0] value;
  } clip_t;

  // clip a wide signed value to the data word
  function automatic clip_t clip_word(input logic [SUM_W-1:0] v);
    clip_t r;
    logic  hi_ones;
    logic  hi_zeros;
    hi_ones  = &v[SUM_W-1:DATA_W-1];
    hi_zeros = ~|v[SUM_W-1:DATA_W-1];
    r.clip   = !(hi_ones || hi_zeros);
    if (r.clip) begin
      r.value = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r.value = v[DATA_W-1:0];
    end
    return r;
  endfunction

  logic        [DATA_W-1:0]  acc;
  logic signed [PROD_W-1:0]  prod;
  logic        [SUM_W-1:0]   sum;
  logic signed [ERR_W-1:0]   mul_a;
  logic signed [ERR_W-1:0]   mul_b;
  logic        [SHIFT_W-1:0] shifted;
  logic        [SUM_W-1:0]   shifted_ext;
  logic        [SUM_W-1:0]   horner_sum;
  clip_t                     horner_clip;
  clip_t                     row_clip;

  // shared multiplier operands
  assign mul_a = {acc[DATA_W-1], acc};
  assign mul_b = ctl.mul_len ? {{(ERR_W-LEN_W){1'b0}}, len} : err;

  // product truncated toward minus infinity
  assign shifted     = prod[PROD_W-1:FRAC_BITS];
  assign shifted_ext = {{(SUM_W-SHIFT_W){shifted[SHIFT_W-1]}}, shifted};
  assign horner_sum  = shifted_ext + {{(SUM_W-DATA_W){rdata[DATA_W-1]}}, rdata};
  assign horner_clip = clip_word(horner_sum);
  assign row_clip    = clip_word(sum);

  // multiply stage
  always_ff @(posedge clk) begin
    if (ctl.mul_len || ctl.mul_err) begin
      prod <= mul_a * mul_b;
    end
  end

  // horner accumulator
  always_ff @(posedge clk) begin
    if (ctl.ld_acc) begin
      acc <= rdata;
    end else if (ctl.horner) begin
      acc <= horner_clip.value;
    end
  end

  // row sum, torques and clip flag
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sum <= '0;
      sat <= 1'b0;
    end else begin
      if (ctl.horner && horner_clip.clip) begin
        sat <= 1'b1;
      end
      if (ctl.add_sum) begin
        sum <= sum + shifted_ext;
      end
      if (ctl.row_end) begin
        sum <= '0;
        if (row_clip.clip) begin
          sat <= 1'b1;
        end
        if (ctl.row) begin
          joint <= row_clip.value;
        end else begin
          wheel <= row_clip.value;
        end
      end
    end
  end

endmodule

// File: design/gain_scheduled_lqr_controller_unit.sv
// Gain-scheduled LQR state feedback, two torques from six states, Q16.16.
// Input channel s_axis_*: tuser selects the item kind. A write item stores
// one cubic coefficient at coef_index (an index past the table end is
// dropped) and gives no result. A compute item carries leg length, six
// states and a velocity reference and gives one result item on m_axis_*:
// wheel torque, joint torque and a saturation flag in tuser.
// A compute item runs a microprogram on one shared 33x33 multiplier and
// the single read port of the coefficient table: each gain is built from
// a table read, the Horner steps and the weighting, in that order. No new
// item is taken while a compute item runs; the next item can be accepted
// as soon as the result is registered.
// If the receiver stalls, the result stays in the output register and the
// block still accepts and runs the next item; it then waits at its last
// step until the previous result is taken.
// Reset clears the sequencer and the output valid; the coefficient table
// is not cleared and must be fully written before the first compute item.
module gain_scheduled_lqr_controller_unit
  import glqr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // coef_index, coef_value, leg_length, body_leg_angle, body_leg_rate,
  // position, velocity, pitch_angle, pitch_rate, velocity_ref
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // wheel_torque, joint_torque
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                   m_axis_tuser
);

  // input field slices
  logic [IDX_W-1:0]  in_index;
  logic [DATA_W-1:0] in_value;
  logic [LEN_W-1:0]  in_len;
  logic [DATA_W-1:0] in_state [NUM_STATES];
  logic [DATA_W-1:0] in_vref;

  assign in_index = s_axis_tdata[5:0];
  assign in_value = s_axis_tdata[37:6];
  assign in_len   = s_axis_tdata[55:38];
  assign in_vref  = s_axis_tdata[279:248];

  for (genvar i = 0; i < NUM_STATES; i++) begin : g_state
    assign in_state[i] = s_axis_tdata[56 + DATA_W*i +: DATA_W];
  end

  logic busy;
  logic accept;
  logic wr_en;
  logic start;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = accept && (s_axis_tuser == OP_WRITE)
                         && ({1'b0, in_index} < (IDX_W+1)'(TABLE_DEPTH));
  assign start         = accept && (s_axis_tuser == OP_COMPUTE);

  // sequencer state
  logic [UPC_W-1:0]     upc;
  logic [UPC_W-1:0]     upc_next;
  logic                 busy_next;
  logic [PTR_W-1:0]     ptr;
  logic [PW_W-1:0]      pw;
  logic [COL_W-1:0]     col;
  logic                 row;
  ucode_t               uc;
  logic                 step_go;
  logic                 pw_more;
  logic                 col_more;

  // captured operands
  logic [LEN_W-1:0]  len;
  logic [ERR_W-1:0]  err [NUM_STATES];
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] coef_mem [TABLE_DEPTH];

  assign uc       = busy ? ucode_rom(upc) : '0;
  assign step_go  = busy && !(uc.emit && m_axis_tvalid && !m_axis_tready);
  assign pw_more  = pw != PW_W'(POLY_DEGREE - 1);
  assign col_more = col != COL_W'(NUM_STATES - 1);

  // next step selection
  always_comb begin
    upc_next  = upc + UPC_W'(1);
    busy_next = busy;
    case (uc.jmp)
      JMP_NEXT: begin
        upc_next = upc + UPC_W'(1);
      end
      JMP_PW_MORE: begin
        if (pw_more) begin
          upc_next = uc.target;
        end
      end
      JMP_COL_MORE: begin
        if (col_more) begin
          upc_next = uc.target;
        end
      end
      JMP_ROW_MORE: begin
        if (!row) begin
          upc_next = uc.target;
        end
      end
      JMP_DONE: begin
        upc_next  = U_RD0;
        busy_next = 1'b0;
      end
      default: begin
        upc_next  = U_RD0;
        busy_next = 1'b0;
      end
    endcase
  end

  // sequencer and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= U_RD0;
      ptr  <= '0;
      pw   <= '0;
      col  <= '0;
      row  <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      upc  <= U_RD0;
      ptr  <= '0;
      pw   <= '0;
      col  <= '0;
      row  <= 1'b0;
    end else if (step_go) begin
      busy <= busy_next;
      upc  <= upc_next;
      if (uc.rd) begin
        ptr <= ptr + PTR_W'(1);
      end
      if (uc.horner) begin
        pw <= pw_more ? pw + PW_W'(1) : '0;
      end
      if (uc.add_sum) begin
        col <= col_more ? col + COL_W'(1) : '0;
      end
      if (uc.row_end) begin
        row <= 1'b1;
      end
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (start) begin
      len <= in_len;
      for (int i = 0; i < NUM_STATES; i++) begin
        if (i == VEL_COL) begin
          // velocity error kept at 33 bits
          err[i] <= {in_state[i][DATA_W-1], in_state[i]} - {in_vref[DATA_W-1], in_vref};
        end else begin
          err[i] <= {in_state[i][DATA_W-1], in_state[i]};
        end
      end
    end
  end

  // coefficient table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[in_index[TAB_AW-1:0]] <= in_value;
    end
    if (uc.rd) begin
      rdata <= coef_mem[ptr[TAB_AW-1:0]];
    end
  end

  // arithmetic
  dp_ctl_t           dp_ctl;
  logic [DATA_W-1:0] wheel;
  logic [DATA_W-1:0] joint;
  logic              sat;

  always_comb begin
    dp_ctl.start   = start;
    dp_ctl.ld_acc  = uc.ld_acc;
    dp_ctl.mul_len = uc.mul_len;
    dp_ctl.horner  = uc.horner;
    dp_ctl.mul_err = uc.mul_err;
    dp_ctl.add_sum = uc.add_sum;
    dp_ctl.row_end = uc.row_end;
    dp_ctl.row     = row;
  end

  glqr_datapath u_datapath (
    .clk   (clk),
    .ctl   (dp_ctl),
    .rdata (rdata),
    .len   (len),
    .err   (err[col]),
    .wheel (wheel),
    .joint (joint),
    .sat   (sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (uc.emit && step_go) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {joint, wheel};
        m_axis_tuser  <= sat;
      end
    end
  end

  // checks
  a_start: assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && upc == U_RD0 && ptr == '0))
    else $error("compute item did not restart the microprogram");

  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (busy && upc == U_EMIT && m_axis_tvalid && !m_axis_tready)
      |=> (busy && upc == U_EMIT))
    else $error("result step left while output register full");

  a_all_read: assert property (@(posedge clk) disable iff (rst)
    (busy && upc == U_EMIT) |-> (ptr == PTR_W'(TABLE_DEPTH)))
    else $error("coefficient reads do not cover the table");

endmodule

// File: verif/glqr_torque_checker.sv
`timescale 1ns / 1ps

module glqr_torque_checker
  import glqr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // coef_index, coef_value, leg_length, six states, velocity_ref
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // wheel_torque, joint_torque
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // saturated
  input  logic                   m_axis_tuser,
  output int                     mismatch_count,
  output int                     torques_pending
);

  // field offsets inside the input item
  localparam int OFS_VAL  = IDX_W;
  localparam int OFS_LEN  = OFS_VAL + DATA_W;
  localparam int OFS_ST   = OFS_LEN + LEN_W;
  localparam int VEL_COL  = 3;
  localparam int VREF_COL = NUM_STATES;

  typedef logic signed [127:0] wide_t;

  localparam wide_t WORD_MAX = 128'sd2147483647;
  localparam wide_t WORD_MIN = -128'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] wheel;
    logic [DATA_W-1:0] joint;
    logic              sat;
  } torque_t;

  logic signed [DATA_W-1:0] coef_tab [TABLE_DEPTH];
  torque_t                  torque_fifo [$];
  int                       errs = 0;

  // clip to signed 32 bits, noting any clip
  function automatic logic signed [DATA_W-1:0] clip_word(input wide_t x, inout logic flag);
    if (x > WORD_MAX) begin
      flag = 1'b1;
      return WORD_MAX[DATA_W-1:0];
    end
    if (x < WORD_MIN) begin
      flag = 1'b1;
      return WORD_MIN[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

  // one scheduled gain by horner, highest power first
  function automatic wide_t gain_at(input int slot, input logic [LEN_W-1:0] len,
                                    inout logic flag);
    wide_t acc;
    acc = coef_tab[slot*NUM_COEFS];
    for (int p = 1; p < NUM_COEFS; p++) begin
      acc = ((acc * $signed({1'b0, len})) >>> FRAC_BITS) + coef_tab[slot*NUM_COEFS + p];
      acc = clip_word(acc, flag);
    end
    return acc;
  endfunction

  // both torques for one compute item
  function automatic torque_t lqr_torques(input logic [IN_TDATA_W-1:0] item);
    wide_t             err [NUM_STATES];
    wide_t             sum;
    wide_t             k;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] word;
    logic              flag;
    torque_t           res;
    len  = item[OFS_LEN +: LEN_W];
    flag = 1'b0;
    res  = '0;
    for (int c = 0; c < NUM_STATES; c++) begin
      err[c] = $signed(item[OFS_ST + DATA_W*c +: DATA_W]);
    end
    // velocity error kept at 33 bits
    err[VEL_COL] = $signed(item[OFS_ST + DATA_W*VEL_COL +: DATA_W])
                 - $signed(item[OFS_ST + DATA_W*VREF_COL +: DATA_W]);
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum = '0;
      for (int c = 0; c < NUM_STATES; c++) begin
        k   = gain_at(r*NUM_STATES + c, len, flag);
        sum = sum + ((k * err[c]) >>> FRAC_BITS);
      end
      word = clip_word(sum, flag);
      if (r == 0) begin
        res.wheel = word;
      end else begin
        res.joint = word;
      end
    end
    res.sat = flag;
    return res;
  endfunction

  task automatic report(input string what, input logic [DATA_W-1:0] want,
                        input logic [DATA_W-1:0] got);
    errs++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endtask

  // watch both channels: results first, then the new input item
  always @(posedge clk) begin : watch
    torque_t          want;
    logic [IDX_W-1:0] slot;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (torque_fifo.size() == 0) begin
          errs++;
          $display("%0t: result with no torque expected, actual %h sat %b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = torque_fifo.pop_front();
          if (m_axis_tdata[DATA_W-1:0] !== want.wheel)
            report("wheel_torque", want.wheel, m_axis_tdata[DATA_W-1:0]);
          if (m_axis_tdata[2*DATA_W-1:DATA_W] !== want.joint)
            report("joint_torque", want.joint, m_axis_tdata[2*DATA_W-1:DATA_W]);
          if (m_axis_tuser !== want.sat)
            report("saturated", {31'b0, want.sat}, {31'b0, m_axis_tuser});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        slot = s_axis_tdata[IDX_W-1:0];
        if (s_axis_tuser == OP_COMPUTE) begin
          torque_fifo.push_back(lqr_torques(s_axis_tdata));
        end else if (slot < TABLE_DEPTH) begin
          coef_tab[slot] = s_axis_tdata[OFS_VAL +: DATA_W];
        end
      end
    end
    mismatch_count  <= errs;
    torques_pending <= torque_fifo.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import glqr_pkg::*;

  localparam int          ITEM_TARGET  = 1900;
  localparam int          SEND_LONGEST = 40;
  localparam int          RECV_LONGEST = 150;
  localparam int          DRAIN_CYCLES = 200;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int          ST_W         = (NUM_STATES + 1) * DATA_W;

  localparam logic [DATA_W-1:0] WORD_HI  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] WORD_LO  = 32'h8000_0000;
  localparam logic [LEN_W-1:0]  LEN_ONE2 = 18'd131072;
  localparam logic [LEN_W-1:0]  LEN_TOP  = 18'h3ffff;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = OP_WRITE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int          mismatch_count;
  int          torques_pending;
  int          items_sent = 0;
  int          stall_left = 0;
  int unsigned cycles = 0;
  logic        steady = 1'b0;

  always #5 clk = ~clk;

  gain_scheduled_lqr_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  glqr_torque_checker torque_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .mismatch_count  (mismatch_count),
    .torques_pending (torques_pending)
  );

  // mostly no pause, some short, a few long
  function automatic int pause_len(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(5, longest);
  endfunction

  function automatic logic [DATA_W-1:0] rand_coef(input int mag);
    case (mag)
      0:       return $urandom_range(0, 2**19) - 2**18;
      1:       return $urandom_range(0, 2**25) - 2**24;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_state_word(input int cls);
    case (cls)
      0: return $urandom_range(0, 2**21) - 2**20;
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0:       return $urandom_range(0, 2**21) - 2**20;
          1:       return WORD_HI;
          2:       return WORD_LO;
          3:       return '0;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // six states plus velocity reference on top
  function automatic logic [ST_W-1:0] rand_states(input int cls);
    logic [ST_W-1:0] v;
    for (int c = 0; c <= NUM_STATES; c++) v[DATA_W*c +: DATA_W] = rand_state_word(cls);
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return LEN_W'($urandom_range(131073, 2**18 - 1));
    if (r < 12) return (r < 10) ? '0 : LEN_ONE2;
    return LEN_W'($urandom_range(0, 131072));
  endfunction

  // one item on the input channel, with a random lead-in gap
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val, input logic [LEN_W-1:0] len,
                           input logic [ST_W-1:0] st);
    int gap;
    gap = steady ? 0 : pause_len(SEND_LONGEST);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {st, len, val, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (!(op == OP_WRITE && idx >= TABLE_DEPTH)) items_sent++;
  endtask

  task automatic write_coef(input int idx, input logic [DATA_W-1:0] val);
    send_item(OP_WRITE, idx[IDX_W-1:0], val, rand_len(), rand_states(1));
  endtask

  task automatic compute(input logic [LEN_W-1:0] len, input logic [ST_W-1:0] st);
    send_item(OP_COMPUTE, IDX_W'($urandom_range(0, 63)), $urandom, len, st);
  endtask

  // full table load in a scrambled order
  task automatic load_table(input int mag);
    int stride;
    int first;
    do stride = 2 * $urandom_range(0, 23) + 1; while (stride % 3 == 0);
    first = $urandom_range(0, TABLE_DEPTH - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      write_coef((first + i * stride) % TABLE_DEPTH, rand_coef(mag));
    end
  endtask

  // receiver with random stalls
  always @(posedge clk) begin : sink
    int n;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      n = steady ? 0 : pause_len(RECV_LONGEST);
      if (n == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left    <= n - 1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ST_W-1:0] st;
    int              mag;
    int              cls;
    int              r;
    logic            first_phase;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: small table, zero and edge lengths
    load_table(0);
    compute('0, '0);
    compute(LEN_ONE2, rand_states(0));
    compute(LEN_TOP, rand_states(0));

    // velocity error beyond 32 bits both ways
    st = rand_states(0);
    st[DATA_W*3 +: DATA_W] = WORD_HI;
    st[DATA_W*6 +: DATA_W] = WORD_LO;
    compute(rand_len(), st);
    st[DATA_W*3 +: DATA_W] = WORD_LO;
    st[DATA_W*6 +: DATA_W] = WORD_HI;
    compute(rand_len(), st);
    compute(LEN_ONE2, {(NUM_STATES + 1){WORD_HI}});
    compute(LEN_ONE2, {(NUM_STATES + 1){WORD_LO}});

    // writes past the table end are dropped
    write_coef(TABLE_DEPTH, WORD_HI);
    write_coef(63, $urandom);
    compute(rand_len(), rand_states(0));

    // two constant full-scale gains: large products that cancel, then add up
    for (int i = 0; i < 2 * NUM_COEFS; i++) begin
      write_coef(i, (i % NUM_COEFS == NUM_COEFS - 1) ? WORD_HI : '0);
    end
    st = '0;
    st[DATA_W*0 +: DATA_W] = WORD_HI;
    st[DATA_W*1 +: DATA_W] = WORD_LO;
    compute(rand_len(), st);
    st[DATA_W*1 +: DATA_W] = WORD_HI;
    compute(rand_len(), st);

    // horner step clipping high and low
    write_coef(2 * NUM_COEFS, WORD_HI);
    compute(LEN_TOP, rand_states(0));
    write_coef(2 * NUM_COEFS, WORD_LO);
    compute(LEN_TOP, rand_states(0));

    // random phases of table contents, state ranges and idling
    first_phase = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      mag    = $urandom_range(0, 2);
      cls    = $urandom_range(0, 2);
      steady = ($urandom_range(0, 4) == 0);
      if (first_phase || $urandom_range(0, 1) == 1) load_table(mag);
      first_phase = 1'b0;
      repeat ($urandom_range(20, 60)) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          compute(rand_len(), rand_states(cls));
        end else if (r < 95) begin
          write_coef($urandom_range(0, TABLE_DEPTH - 1), rand_coef(mag));
        end else begin
          write_coef($urandom_range(TABLE_DEPTH, 63), $urandom);
        end
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain the remaining results, then watch for strays
    @(posedge clk);
    while (torques_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && torques_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
design/glqr_pkg.sv
design/glqr_datapath.sv
design/gain_scheduled_lqr_controller_unit.sv
verif/glqr_torque_checker.sv
verif/tb_top.sv
